// ===== rtl/ffa_pkg.sv =====
// Shared constants, widths and types of the first-fit chunk allocator.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package ffa_pkg;

	localparam int NUM_CHUNKS  = 256;
	localparam int CHUNK_BYTES = 33;

	localparam int IDX_W  = $clog2(NUM_CHUNKS);
	localparam int LEN_W  = IDX_W + 1;
	localparam int CFG_W  = 9;
	localparam int SIZE_W = 16;

	// largest chunk count a request can ask for
	localparam int MAX_NEED = ((2 ** SIZE_W) - 1 + CHUNK_BYTES - 1) / CHUNK_BYTES;
	localparam int NEED_W   = $clog2(MAX_NEED + 1);

	// reciprocal divide: floor(x / CHUNK_BYTES) = (x * DIV_K) >> DIV_S, exact for x < 2**DIV_N
	localparam int DIV_N   = SIZE_W + 1;
	localparam int DIV_S   = DIV_N + $clog2(CHUNK_BYTES) + 1;
	localparam longint DIV_K = ((64'd1 << DIV_S) + CHUNK_BYTES - 1) / CHUNK_BYTES;
	localparam int DIV_K_W = $clog2(DIV_K + 1);
	localparam int PROD_W  = DIV_N + DIV_K_W;

	localparam logic [CFG_W-1:0] POOL_RESET = CFG_W'(256);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// one request to the run-length store
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic             clr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [LEN_W-1:0] wr_data;
	} store_req_t;

	// result of the shared scan step
	typedef struct packed {
		logic [LEN_W-1:0] next;
		logic             zero;
		logic             in_pool;
	} step_t;

endpackage

// ===== rtl/ffa_need.sv =====
// Byte size to chunk count (round up) by reciprocal multiply, one registered stage.
// Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_need (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ffa_pkg::SIZE_W-1:0] size,
	output logic [ffa_pkg::NEED_W-1:0] need_q
);

	logic [ffa_pkg::DIV_N-1:0]  x;
	logic [ffa_pkg::PROD_W-1:0] prod;

	assign x    = ffa_pkg::DIV_N'(size) + ffa_pkg::DIV_N'(ffa_pkg::CHUNK_BYTES - 1);
	assign prod = ffa_pkg::PROD_W'(x) * ffa_pkg::PROD_W'(ffa_pkg::DIV_K);

	always_ff @(posedge clk) begin
		if (en) begin
			need_q <= prod[ffa_pkg::DIV_S +: ffa_pkg::NEED_W];
		end
	end

endmodule

// ===== rtl/ffa_store.sv =====
// Run-length store: one memory with registered read, plus per-entry valid bits
// so that reset reads as all zero. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ffa_pkg::store_req_t       req,
	output logic [ffa_pkg::LEN_W-1:0] rd_data_q
);

	logic [ffa_pkg::LEN_W-1:0]      mem [ffa_pkg::NUM_CHUNKS];
	logic [ffa_pkg::NUM_CHUNKS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= valid_q[req.rd_addr] ? mem[req.rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end else if (req.clr_en) begin
			valid_q[req.wr_addr] <= 1'b0;
		end
	end

endmodule

// ===== rtl/ffa_step.sv =====
// Shared scan step: advance one chunk over a free entry or skip a used run,
// and test the position against the active pool. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_step (
	input  logic [ffa_pkg::LEN_W-1:0] cur,
	input  logic [ffa_pkg::LEN_W-1:0] len,
	input  logic [ffa_pkg::LEN_W-1:0] pool,
	output ffa_pkg::step_t            step
);

	always_comb begin
		step.zero    = (len == '0);
		step.in_pool = (cur < pool);
		step.next    = cur + (step.zero ? ffa_pkg::LEN_W'(1) : len);
	end

endmodule

// ===== rtl/fixed_chunk_first_fit_allocator_core.sv =====
// First-fit allocator over a pool of fixed-size chunks: top level and sequencer.
// Depends on ffa_pkg, ffa_need, ffa_store and ffa_step.
`timescale 1ns / 1ps

// One request at a time. An allocate sizes the request and sets up, then
// the first-fit scan visits positions (a free chunk or a skipped run), then
// the hint search walks the positions after the new run, with one more step
// where either walk runs off the pool end, then the result is posted. The
// scan speed is set by the run-length store: its single read port feeds the
// next scan address through one shared step adder each cycle. A free reads
// the entry, updates it and posts the result. A request that fails (size 0,
// too large, no room) posts ok=0 with alloc_index 0 and leaves the pool as
// it was. in_ready is high only while the sequencer is idle; the result
// register lets the next request start while a result still waits on
// out_ready. cfg_ready is always high; a write changes only the pool size.
// It takes effect on the next request only if the user writes between
// requests; the block does not enforce this. The store needs no clearing pass after reset.

module fixed_chunk_first_fit_allocator_core (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ffa_pkg::CFG_W-1:0]  cfg_data,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic [ffa_pkg::SIZE_W-1:0] size_bytes,
	input  logic [ffa_pkg::IDX_W-1:0]  free_index,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       ok,
	output logic [ffa_pkg::IDX_W-1:0]  alloc_index,
	output logic                       pool_empty
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_HINT  = 3'd3;
	localparam logic [2:0] ST_FREE  = 3'd4;
	localparam logic [2:0] ST_RESP  = 3'd5;

	logic [2:0]                 state_q;
	logic [ffa_pkg::CFG_W-1:0]  pool_chunks_q;
	logic [ffa_pkg::LEN_W-1:0]  pool_act;
	logic [ffa_pkg::IDX_W-1:0]  hint_q;
	logic [ffa_pkg::LEN_W-1:0]  live_q;
	logic [ffa_pkg::LEN_W-1:0]  pos_q;     // scan position
	logic [ffa_pkg::LEN_W-1:0]  count_q;   // free chunks in the current run
	logic [ffa_pkg::IDX_W-1:0]  first_q;   // start of the current free run
	logic [ffa_pkg::IDX_W-1:0]  idx_q;     // free request index
	logic                       res_ok_q;
	logic [ffa_pkg::IDX_W-1:0]  res_idx_q;
	logic                       out_valid_q;
	logic                       ok_q;
	logic [ffa_pkg::IDX_W-1:0]  alloc_index_q;
	logic                       pool_empty_q;

	logic                       in_acc;
	logic                       resp_load;
	logic [ffa_pkg::NEED_W-1:0] need_q;
	logic [ffa_pkg::LEN_W-1:0]  rd_data;
	ffa_pkg::step_t             step;
	ffa_pkg::store_req_t        req;
	logic                       need_bad;
	logic                       run_done;
	logic [ffa_pkg::IDX_W-1:0]  run_start;
	logic                       free_hit;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign resp_load = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	assign pool_act = (pool_chunks_q > ffa_pkg::CFG_W'(ffa_pkg::NUM_CHUNKS)) ?
		ffa_pkg::LEN_W'(ffa_pkg::NUM_CHUNKS) : ffa_pkg::LEN_W'(pool_chunks_q);

	// size 0 rounds to zero chunks
	assign need_bad  = (need_q == '0) || (need_q > ffa_pkg::NEED_W'(pool_act));
	assign run_start = (count_q == '0) ? pos_q[ffa_pkg::IDX_W-1:0] : first_q;
	assign run_done  = (ffa_pkg::NEED_W'(count_q + ffa_pkg::LEN_W'(1)) == need_q);
	assign free_hit  = (rd_data != '0) &&
		({1'b0, idx_q} < ffa_pkg::LEN_W'(ffa_pkg::NUM_CHUNKS));

	ffa_need u_need (
		.clk    (clk),
		.en     (in_acc),
		.size   (size_bytes),
		.need_q (need_q)
	);

	ffa_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_data_q (rd_data)
	);

	ffa_step u_step (
		.cur  (pos_q),
		.len  (rd_data),
		.pool (pool_act),
		.step (step)
	);

	// store requests; each scan cycle reads the position the step unit picks
	always_comb begin
		req         = '0;
		req.wr_addr = run_start;
		req.wr_data = need_q[ffa_pkg::LEN_W-1:0];
		case (state_q)
			ST_IDLE: begin
				req.rd_en   = in_acc && (cmd == ffa_pkg::CMD_FREE);
				req.rd_addr = free_index;
			end
			ST_CHECK: begin
				req.rd_en   = !need_bad;
				req.rd_addr = hint_q;
			end
			ST_SCAN, ST_HINT: begin
				req.rd_en   = step.in_pool;
				req.rd_addr = step.next[ffa_pkg::IDX_W-1:0];
				req.wr_en   = (state_q == ST_SCAN) && step.in_pool && step.zero && run_done;
			end
			ST_FREE: begin
				req.clr_en  = free_hit;
				req.wr_addr = idx_q;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_chunks_q <= ffa_pkg::POOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pool_chunks_q <= cfg_data;
		end
	end

	// sequencer and allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hint_q  <= '0;
			live_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (cmd == ffa_pkg::CMD_FREE) ? ST_FREE : ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= need_bad ? ST_RESP : ST_SCAN;
				end
				ST_SCAN: begin
					if (!step.in_pool) begin
						state_q <= ST_RESP;
					end else if (step.zero && run_done) begin
						live_q  <= live_q + ffa_pkg::LEN_W'(1);
						state_q <= ST_HINT;
					end
				end
				ST_HINT: begin
					if (!step.in_pool) begin
						state_q <= ST_RESP;
					end else if (step.zero) begin
						hint_q  <= pos_q[ffa_pkg::IDX_W-1:0];
						state_q <= ST_RESP;
					end
				end
				ST_FREE: begin
					if (free_hit) begin
						if (live_q != '0) begin
							live_q <= live_q - ffa_pkg::LEN_W'(1);
						end
						if (idx_q < hint_q) begin
							hint_q <= idx_q;
						end
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (resp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the scan and the pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q     <= free_index;
				res_ok_q  <= 1'b0;
				res_idx_q <= '0;
			end
			ST_CHECK: begin
				pos_q   <= {1'b0, hint_q};
				count_q <= '0;
			end
			ST_SCAN: begin
				pos_q <= step.next;
				if (step.in_pool && step.zero) begin
					first_q <= run_start;
					count_q <= count_q + ffa_pkg::LEN_W'(1);
					if (run_done) begin
						res_ok_q  <= 1'b1;
						res_idx_q <= run_start;
					end
				end else begin
					count_q <= '0;
				end
			end
			ST_HINT: begin
				if (!step.zero) begin
					pos_q <= step.next;
				end
			end
			ST_FREE: begin
				res_ok_q <= free_hit;
			end
			default: begin
				res_ok_q <= res_ok_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			ok_q          <= res_ok_q;
			alloc_index_q <= res_idx_q;
			pool_empty_q  <= (live_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign alloc_index = alloc_index_q;
	assign pool_empty  = pool_empty_q;

`ifndef SYNTHESIS
	// a request is worked alone: no second accept right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");

	// failed results never carry a start index
	a_fail_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> alloc_index == '0)
		else $error("failed result with nonzero alloc_index");

	// the store is never written and cleared in one cycle
	a_store_single_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr_en && req.clr_en))
		else $error("store write and clear collide");

	// a free run under construction never reaches the requested count
	a_count_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> ffa_pkg::NEED_W'(count_q) < need_q)
		else $error("scan run count reached need without allocating");
`endif

endmodule

// ===== bench/ffa_checker.sv =====
// Checker for the first-fit chunk allocator: watches the config, request and result channels.
// Keeps its own copy of the pool state to predict each result. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_checker
	import ffa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,

	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              cmd,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [IDX_W-1:0]  free_index,

	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              ok,
	input  logic [IDX_W-1:0]  alloc_index,
	input  logic              pool_empty,

	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] index;
		logic             empty;
	} alloc_result_t;

	alloc_result_t    expected_results [$];

	// shadow of the allocator state
	logic [LEN_W-1:0] chunk_run [NUM_CHUNKS];
	logic [IDX_W-1:0] scan_hint;
	logic [LEN_W-1:0] live_allocs;
	logic [CFG_W-1:0] pool_setting;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic alloc_result_t predict_request(input logic c,
			input logic [SIZE_W-1:0] sz, input logic [IDX_W-1:0] fi);
		alloc_result_t r;
		int pool;
		int need;
		int i;
		int j;
		int count;
		int first;
		bit found;
		r = '0;
		pool = int'(pool_setting);
		if (pool > NUM_CHUNKS) pool = NUM_CHUNKS;
		if (pool > 256) pool = 256;
		if (c == CMD_ALLOC) begin
			need = (int'(sz) + CHUNK_BYTES - 1) / CHUNK_BYTES;
			if (sz != '0 && need <= pool) begin
				i = int'(scan_hint);
				count = 0;
				first = 0;
				found = 1'b0;
				while (i < pool && !found) begin
					if (chunk_run[i] == '0) begin
						if (count == 0) first = i;
						count++;
						if (count == need) begin
							found = 1'b1;
							chunk_run[first] = LEN_W'(need);
							live_allocs = live_allocs + 1'b1;
							// move the hint past the new run; keep it if nothing is free
							j = i + 1;
							while (j < pool) begin
								if (chunk_run[j] == '0) begin
									scan_hint = IDX_W'(j);
									break;
								end
								j += int'(chunk_run[j]);
							end
							r.ok = 1'b1;
							r.index = IDX_W'(first);
						end
						i++;
					end else begin
						count = 0;
						i += int'(chunk_run[i]);
					end
				end
			end
		end else begin
			if (int'(fi) < NUM_CHUNKS && chunk_run[fi] != '0) begin
				chunk_run[fi] = '0;
				if (live_allocs != '0) live_allocs = live_allocs - 1'b1;
				if (fi < scan_hint) scan_hint = fi;
				r.ok = 1'b1;
			end
		end
		r.empty = (live_allocs == '0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		alloc_result_t want;
		if (!arst_n) begin
			for (int n = 0; n < NUM_CHUNKS; n++) chunk_run[n] = '0;
			scan_hint = '0;
			live_allocs = '0;
			pool_setting = POOL_RESET;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// retire first: a result never belongs to the request taken on the same edge
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request pending", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (ok !== want.ok)
						report_mismatch("ok", int'(ok), int'(want.ok));
					if (alloc_index !== want.index)
						report_mismatch("alloc_index", int'(alloc_index), int'(want.index));
					if (pool_empty !== want.empty)
						report_mismatch("pool_empty", int'(pool_empty), int'(want.empty));
				end
			end
			if (cfg_valid && cfg_ready) pool_setting = cfg_data;
			if (in_valid && in_ready)
				expected_results.push_back(predict_request(cmd, size_bytes, free_index));
			pending = expected_results.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the allocator bench: clock, reset, request stimulus, receiver stalls and verdict.
// Depends on ffa_pkg, ffa_checker and the fixed_chunk_first_fit_allocator_core RTL.
`timescale 1ns / 1ps

module tb_top;

	import ffa_pkg::*;

	// Neither an allocate over a full pool nor the long receiver hold-off below
	// comes near the watchdog limit; nothing legal goes that long without a handshake.
	localparam int WATCHDOG_LIMIT    = 4000;
	localparam int HOLD_CYCLES       = 600;
	localparam int ITEMS_PER_SETTING = 225;
	localparam int DRAIN_CYCLES      = 300;
	localparam int CB                = CHUNK_BYTES;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              cmd;
	logic [SIZE_W-1:0] size_bytes;
	logic [IDX_W-1:0]  free_index;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              ok;
	logic [IDX_W-1:0]  alloc_index;
	logic              pool_empty;

	int fail_count;
	int pending;

	// idle percentages per cycle; changed only between requests
	int send_idle_pct;
	int recv_idle_pct;
	// hold-off requests from the main flow, counted; the receiver tracks them
	int hold_req;
	int hold_seen = 0;
	int hold_left = 0;

	// stimulus bookkeeping: commands in flight and run starts that came back live
	logic             cmd_in_flight [$];
	logic [IDX_W-1:0] live_starts   [$];

	// pool sizes walked by the random part: extremes, zero, an oversize value
	int pool_plan [8] = '{256, 1, 0, 37, 511, 8, 100, 256};

	fixed_chunk_first_fit_allocator_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.size_bytes  (size_bytes),
		.free_index  (free_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.alloc_index (alloc_index),
		.pool_empty  (pool_empty)
	);

	ffa_checker alloc_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.size_bytes  (size_bytes),
		.free_index  (free_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.alloc_index (alloc_index),
		.pool_empty  (pool_empty),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls at the falling edge. A hold request from the
	// main flow parks out_ready low for a long stretch so that the result
	// register and the sequencer both fill and in_ready drops.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Harvest run starts of successful allocates so frees can aim at live runs.
	// Retire before issue, same as the checker.
	always @(posedge clk) begin : harvest
		logic c;
		if (out_valid && out_ready && cmd_in_flight.size() > 0) begin
			c = cmd_in_flight.pop_front();
			if (c == CMD_ALLOC && ok) live_starts.push_back(alloc_index);
		end
		if (in_valid && in_ready) cmd_in_flight.push_back(cmd);
	end

	// Watchdog: too long without any handshake ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// Offer one request. Valid stays high from the accepting edge until the
	// next falling edge decides between a gap and the next request.
	task automatic send_req(input logic c, input logic [SIZE_W-1:0] sz,
			input logic [IDX_W-1:0] fi);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		size_bytes <= sz;
		free_index <= fi;
		do @(posedge clk); while (!in_ready);
	endtask

	// Wait until every expected result is back, then write the pool size.
	task automatic write_pool(input int chunks);
		@(negedge clk);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(chunks);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed traffic: small allocates and frees of live starts;
	// the rest zero sizes, full-range sizes and frees of random indexes.
	task automatic send_random();
		int r;
		int pos;
		logic [SIZE_W-1:0] sz;
		logic [IDX_W-1:0] fi;
		r = $urandom_range(0, 99);
		if (r < 58) begin
			r = $urandom_range(0, 99);
			if (r < 5)       sz = '0;
			else if (r < 15) sz = SIZE_W'($urandom);
			else if (r < 25) sz = SIZE_W'($urandom_range(1, CB * 64));
			else             sz = SIZE_W'($urandom_range(1, CB * 8));
			send_req(CMD_ALLOC, sz, IDX_W'($urandom));
		end else begin
			if (live_starts.size() > 0 && $urandom_range(0, 99) < 75) begin
				pos = $urandom_range(0, live_starts.size() - 1);
				fi = live_starts[pos];
				live_starts.delete(pos);
			end else begin
				fi = IDX_W'($urandom);
			end
			send_req(CMD_FREE, SIZE_W'($urandom), fi);
		end
	endtask

	initial begin : stimulus
		int gk;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_ALLOC;
		size_bytes = '0;
		free_index = '0;
		send_idle_pct = 22;
		recv_idle_pct = 60;
		hold_req = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_pool(int'(POOL_RESET));

		// directed walk over a full pool
		send_req(CMD_ALLOC, 16'd0, 8'd0);                 // zero size
		send_req(CMD_ALLOC, 16'd1, 8'd0);                 // one chunk at 0
		send_req(CMD_ALLOC, SIZE_W'(CB), 8'd0);           // exactly one chunk
		send_req(CMD_ALLOC, SIZE_W'(CB + 1), 8'd0);       // rounds up to two
		send_req(CMD_ALLOC, 16'hFFFF, 8'd0);              // larger than the pool
		send_req(CMD_ALLOC, SIZE_W'(CB * 250), 8'hFF);    // big run, hint to 254
		send_req(CMD_ALLOC, SIZE_W'(CB * 3), 8'd0);       // no room
		send_req(CMD_ALLOC, SIZE_W'(CB * 2), 8'd0);       // fills the tail, hint kept
		send_req(CMD_ALLOC, 16'd1, 8'd0);                 // skip runs past the pool end
		send_req(CMD_FREE, 16'hFFFF, 8'd1);               // lowers the hint
		send_req(CMD_FREE, 16'd0, 8'd1);                  // double free
		send_req(CMD_FREE, 16'd0, 8'd200);                // inside a run, not a start
		send_req(CMD_FREE, 16'd0, 8'd255);
		send_req(CMD_ALLOC, SIZE_W'(CB), 8'd0);           // reuses the freed hole
		send_req(CMD_FREE, 16'd0, 8'd0);
		send_req(CMD_FREE, 16'd0, 8'd1);
		send_req(CMD_FREE, 16'd0, 8'd2);
		send_req(CMD_FREE, 16'd0, 8'd4);
		send_req(CMD_FREE, 16'd0, 8'd254);                // pool empty again
		send_req(CMD_ALLOC, SIZE_W'(CB * 256), 8'd0);     // whole pool in one run
		send_req(CMD_ALLOC, 16'd1, 8'd0);                 // nothing left
		send_req(CMD_FREE, 16'd0, 8'd0);

		// random part; the store and hint carry over across pool changes
		gk = 0;
		for (int p = 0; p < 8; p++) begin
			write_pool(pool_plan[p]);
			for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
				// idle profile: sender light / receiver heavy, swapped, then none
				if (gk < 600) begin
					send_idle_pct = 22;
					recv_idle_pct = 60;
				end else if (gk < 1200) begin
					send_idle_pct = 60;
					recv_idle_pct = 22;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				// long receiver hold-off while requests keep coming
				if (gk == 300 || gk == 1500) hold_req++;
				send_random();
				gk++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		// let a stray late result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
